/* hdl/cxa_pkg.sv */
`default_nettype none

package cxa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int MODE_BITS = 3;
    localparam int STAT_BITS = 2;
    // exact sum of two full products, with headroom for the serial accumulate
    localparam int PROD_BITS = 2 * WORD_BITS + 2;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [PROD_BITS-1:0] t_prod;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [MODE_BITS-1:0] {
        MODE_LOAD = MODE_BITS'(0),
        MODE_ADD  = MODE_BITS'(1),
        MODE_SUB  = MODE_BITS'(2),
        MODE_MUL  = MODE_BITS'(3),
        MODE_DIV  = MODE_BITS'(4),
        MODE_READ = MODE_BITS'(5)
    } t_mode;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK       = STAT_BITS'(0),
        ST_DIV_ZERO = STAT_BITS'(1),
        ST_SAT      = STAT_BITS'(2)
    } t_status;

    typedef struct packed {
        logic start;
        logic sub;
    } t_dot_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

/* hdl/cxa_if.sv */
`default_nettype none

interface cxa_in_if;
    logic                                valid;
    logic                                ready;
    logic [cxa_pkg::MODE_BITS-1:0]       mode;
    logic signed [cxa_pkg::WORD_BITS-1:0] operand_real;
    logic signed [cxa_pkg::WORD_BITS-1:0] operand_imag;

    modport source (output valid, output mode, output operand_real, output operand_imag,
                    input ready);
    modport sink   (input valid, input mode, input operand_real, input operand_imag,
                    output ready);
endinterface

interface cxa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [cxa_pkg::WORD_BITS-1:0] result_real;
    logic signed [cxa_pkg::WORD_BITS-1:0] result_imag;
    logic [cxa_pkg::STAT_BITS-1:0]       status;

    modport source (output valid, output result_real, output result_imag, output status,
                    input ready);
    modport sink   (input valid, input result_real, input result_imag, input status,
                    output ready);
endinterface

`default_nettype wire

/* hdl/cxa_dot.sv */
`default_nettype none

// Bit-serial x0*y0 +/- x1*y1, one bit of each multiplier per cycle, LSB first.
module cxa_dot (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cxa_pkg::t_dot_ctl     i_ctl,
    input  wire cxa_pkg::t_word        i_x0,
    input  wire cxa_pkg::t_word        i_y0,
    input  wire cxa_pkg::t_word        i_x1,
    input  wire cxa_pkg::t_word        i_y1,
    output cxa_pkg::t_prod             o_prod,
    output cxa_pkg::t_unit_stat        o_stat
);

    localparam int W  = cxa_pkg::WORD_BITS;
    localparam int CB = cxa_pkg::CNT_BITS;

    logic signed [W-1:0] r_x0;
    logic signed [W:0]   r_x1n;
    logic [W-1:0]        r_y0;
    logic [W-1:0]        r_y1;
    logic signed [W+1:0] r_p;
    logic [W-1:0]        r_lo;
    logic [CB-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;

    logic signed [W+2:0] w_t;
    logic signed [W+2:0] w_s;
    logic                w_last;
    logic signed [W+1:0] n_p;
    logic [W-1:0]        n_lo;

    assign w_last = (r_cnt == CB'(W - 1));
    assign w_t    = (r_y0[0] ? (W+3)'(r_x0)  : {(W+3){1'b0}})
                  + (r_y1[0] ? (W+3)'(r_x1n) : {(W+3){1'b0}});
    // sign bit of the multiplier carries negative weight
    assign w_s    = w_last ? ((W+3)'(r_p) - w_t) : ((W+3)'(r_p) + w_t);
    assign n_p    = w_s[W+2:1];
    assign n_lo   = {w_s[0], r_lo[W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CB'(1);
            if (w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x0  <= i_x0;
            r_x1n <= i_ctl.sub ? -((W+1)'(i_x1)) : (W+1)'(i_x1);
            r_y0  <= i_y0;
            r_y1  <= i_y1;
            r_p   <= '0;
        end else if (r_busy) begin
            r_p  <= n_p;
            r_lo <= n_lo;
            r_y0 <= r_y0 >> 1;
            r_y1 <= r_y1 >> 1;
        end
    end

    assign o_prod = {r_p, r_lo};
    assign o_stat = '{busy: r_busy, done: r_done};

endmodule

`default_nettype wire

/* hdl/cxa_div.sv */
`default_nettype none

// Restoring divider: (|num| << FRAC_BITS) / den, one quotient bit per cycle,
// clamped to the signed word range.
module cxa_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire cxa_pkg::t_prod                     i_num,
    input  wire logic [2*cxa_pkg::WORD_BITS-1:0]    i_den,
    output cxa_pkg::t_word                          o_quo,
    output logic                                    o_sat,
    output cxa_pkg::t_unit_stat                     o_stat
);

    localparam int W  = cxa_pkg::WORD_BITS;
    localparam int F  = cxa_pkg::FRAC_BITS;
    localparam int PW = cxa_pkg::PROD_BITS;
    localparam int CB = cxa_pkg::CNT_BITS;

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_CHK  = 4'b0010,
        D_RUN  = 4'b0100,
        D_DONE = 4'b1000
    } t_dstate;

    t_dstate          r_state;
    logic [CB-1:0]    r_cnt;
    logic             r_neg;
    logic [2*W-1:0]   r_mag;
    logic [2*W-1:0]   r_den;
    logic [2*W-1:0]   r_rem;
    logic [W-1:0]     r_lo;
    logic [W-1:0]     r_q;
    logic             r_ovf;

    cxa_pkg::t_prod   w_neg_num;
    logic [3*W-1:0]   w_full;
    logic [2*W:0]     w_trial;
    logic [2*W+1:0]   w_diff;
    logic             w_geq;
    logic             w_last;

    assign w_neg_num = -i_num;
    assign w_full    = (3*W)'(r_mag) << F;
    assign w_trial   = {r_rem, r_lo[W-1]};
    assign w_diff    = {1'b0, w_trial} - {2'b00, r_den};
    assign w_geq     = !w_diff[2*W+1];
    assign w_last    = (r_cnt == CB'(W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_state <= D_CHK;
        end else begin
            case (r_state)
                D_CHK: begin
                    r_cnt   <= '0;
                    r_state <= D_RUN;
                end
                D_RUN: begin
                    r_cnt <= r_cnt + CB'(1);
                    if (w_last) begin
                        r_state <= D_DONE;
                    end
                end
                D_IDLE, D_DONE: begin
                    r_state <= r_state;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[PW-1];
            r_mag <= i_num[PW-1] ? w_neg_num[2*W-1:0] : i_num[2*W-1:0];
            r_den <= i_den;
        end else if (r_state == D_CHK) begin
            // quotient of 2^W or more cannot fit any signed word
            r_rem <= w_full[3*W-1:W];
            r_lo  <= w_full[W-1:0];
            r_ovf <= (w_full[3*W-1:W] >= r_den);
            r_q   <= '0;
        end else if (r_state == D_RUN) begin
            r_rem <= w_geq ? w_diff[2*W-1:0] : w_trial[2*W-1:0];
            r_q   <= {r_q[W-2:0], w_geq};
            r_lo  <= r_lo << 1;
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_sat = r_ovf | r_q[W-1];
            o_quo = o_sat ? cxa_pkg::WORD_MAX : cxa_pkg::t_word'(r_q);
        end else begin
            o_sat = r_ovf | (r_q[W-1] & (|r_q[W-2:0]));
            o_quo = o_sat ? cxa_pkg::WORD_MIN : cxa_pkg::t_word'(-r_q);
        end
    end

    assign o_stat = '{busy: (r_state == D_CHK) || (r_state == D_RUN),
                      done: (r_state == D_DONE)};

endmodule

`default_nettype wire

/* hdl/complex_accumulator_alu.sv */
`default_nettype none

// channel  dir  handshake    word
// i_in     in   valid/ready  mode[2:0], operand_real[31:0], operand_imag[31:0]
// o_out    out  valid/ready  result_real[31:0], result_imag[31:0], status[1:0]
//
// Load, add, subtract, read and a rejected zero divide go from S_IDLE straight to S_FIN.
// Multiply runs in S_DOT on the bit-serial product units, then ends in S_FIN.
// Divide runs the serial products in S_DOT, then the restoring divider in S_DIV
// at one quotient bit per cycle.
// i_rst_n is synchronous: it clears the accumulator and drops any result held.
// A held result waiting on o_out.ready does not block the next input word;
// only the final write-back waits for the output register to free up.
module complex_accumulator_alu (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cxa_in_if.sink     i_in,
    cxa_out_if.source  o_out
);

    localparam int W  = cxa_pkg::WORD_BITS;
    localparam int F  = cxa_pkg::FRAC_BITS;
    localparam int PW = cxa_pkg::PROD_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DOT  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    typedef struct packed {
        logic           sat;
        cxa_pkg::t_word val;
    } t_sat_word;

    // add or subtract with clamp to the word range
    function automatic t_sat_word add_sat(input cxa_pkg::t_word a,
                                          input cxa_pkg::t_word b,
                                          input logic sub);
        logic signed [W:0] sum;
        t_sat_word         r;
        sum   = (W+1)'(a) + (sub ? -((W+1)'(b)) : (W+1)'(b));
        r.sat = (sum[W] != sum[W-1]);
        r.val = r.sat ? (sum[W] ? cxa_pkg::WORD_MIN : cxa_pkg::WORD_MAX) : sum[W-1:0];
        return r;
    endfunction

    // drop the fraction (floor) and clamp the exact product sum to a word
    function automatic t_sat_word clip_prod(input cxa_pkg::t_prod p);
        cxa_pkg::t_prod sh;
        logic           fits;
        t_sat_word      r;
        sh    = p >>> F;
        fits  = (&sh[PW-1:W-1]) | ~(|sh[PW-1:W-1]);
        r.sat = !fits;
        r.val = fits ? sh[W-1:0] : (sh[PW-1] ? cxa_pkg::WORD_MIN : cxa_pkg::WORD_MAX);
        return r;
    endfunction

    t_state                r_state;
    cxa_pkg::t_word        r_acc_re;
    cxa_pkg::t_word        r_acc_im;
    logic                  r_is_div;
    cxa_pkg::t_word        r_pend_re;
    cxa_pkg::t_word        r_pend_im;
    cxa_pkg::t_status      r_pend_st;
    logic                  r_out_valid;
    cxa_pkg::t_word        r_out_re;
    cxa_pkg::t_word        r_out_im;
    cxa_pkg::t_status      r_out_st;

    t_state                n_state;
    cxa_pkg::t_word        n_pend_re;
    cxa_pkg::t_word        n_pend_im;
    cxa_pkg::t_status      n_pend_st;
    logic                  n_is_div;

    cxa_pkg::t_mode        w_mode;
    logic                  w_accept;
    logic                  w_is_mul;
    logic                  w_zero_den;
    logic                  w_out_free;
    logic                  w_dot_start;
    logic                  w_div_start;
    logic                  w_dots_done;
    logic                  w_divs_done;
    t_sat_word             w_as_re;
    t_sat_word             w_as_im;
    t_sat_word             w_mc_re;
    t_sat_word             w_mc_im;

    cxa_pkg::t_dot_ctl     w_dot0_ctl;
    cxa_pkg::t_dot_ctl     w_dot1_ctl;
    cxa_pkg::t_dot_ctl     w_dot2_ctl;
    cxa_pkg::t_word        w_d1_x0;
    cxa_pkg::t_word        w_d1_y0;
    cxa_pkg::t_word        w_d1_x1;
    cxa_pkg::t_word        w_d1_y1;
    cxa_pkg::t_prod        w_dot0_prod;
    cxa_pkg::t_prod        w_dot1_prod;
    cxa_pkg::t_prod        w_dot2_prod;
    cxa_pkg::t_unit_stat   w_dot0_stat;
    cxa_pkg::t_unit_stat   w_dot1_stat;
    cxa_pkg::t_unit_stat   w_dot2_stat;
    cxa_pkg::t_word        w_div0_quo;
    cxa_pkg::t_word        w_div1_quo;
    logic                  w_div0_sat;
    logic                  w_div1_sat;
    cxa_pkg::t_unit_stat   w_div0_stat;
    cxa_pkg::t_unit_stat   w_div1_stat;

    assign w_mode      = cxa_pkg::t_mode'(i_in.mode);
    // hold the input closed while in reset
    assign i_in.ready  = i_rst_n && (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_is_mul    = (w_mode == cxa_pkg::MODE_MUL);
    assign w_zero_den  = (i_in.operand_real == '0) && (i_in.operand_imag == '0);
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_dots_done = w_dot0_stat.done && w_dot1_stat.done && w_dot2_stat.done;
    assign w_divs_done = w_div0_stat.done && w_div1_stat.done;

    assign w_as_re = add_sat(r_acc_re, i_in.operand_real, w_mode == cxa_pkg::MODE_SUB);
    assign w_as_im = add_sat(r_acc_im, i_in.operand_imag, w_mode == cxa_pkg::MODE_SUB);
    assign w_mc_re = clip_prod(w_dot0_prod);
    assign w_mc_im = clip_prod(w_dot1_prod);

    // Product units. Multiply: ac - bd and ad + bc. Divide: ac + bd, bc - ad
    // and the divisor c^2 + d^2.
    assign w_dot0_ctl = '{start: w_dot_start, sub: w_is_mul};
    assign w_dot1_ctl = '{start: w_dot_start, sub: !w_is_mul};
    assign w_dot2_ctl = '{start: w_dot_start, sub: 1'b0};

    assign w_d1_x0 = w_is_mul ? r_acc_re          : r_acc_im;
    assign w_d1_y0 = w_is_mul ? i_in.operand_imag : i_in.operand_real;
    assign w_d1_x1 = w_is_mul ? r_acc_im          : r_acc_re;
    assign w_d1_y1 = w_is_mul ? i_in.operand_real : i_in.operand_imag;

    cxa_dot u_dot0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dot0_ctl),
        .i_x0    (r_acc_re),
        .i_y0    (i_in.operand_real),
        .i_x1    (r_acc_im),
        .i_y1    (i_in.operand_imag),
        .o_prod  (w_dot0_prod),
        .o_stat  (w_dot0_stat)
    );

    cxa_dot u_dot1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dot1_ctl),
        .i_x0    (w_d1_x0),
        .i_y0    (w_d1_y0),
        .i_x1    (w_d1_x1),
        .i_y1    (w_d1_y1),
        .o_prod  (w_dot1_prod),
        .o_stat  (w_dot1_stat)
    );

    cxa_dot u_dot2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dot2_ctl),
        .i_x0    (i_in.operand_real),
        .i_y0    (i_in.operand_real),
        .i_x1    (i_in.operand_imag),
        .i_y1    (i_in.operand_imag),
        .o_prod  (w_dot2_prod),
        .o_stat  (w_dot2_stat)
    );

    cxa_div u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dot0_prod),
        .i_den   (w_dot2_prod[2*W-1:0]),
        .o_quo   (w_div0_quo),
        .o_sat   (w_div0_sat),
        .o_stat  (w_div0_stat)
    );

    cxa_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dot1_prod),
        .i_den   (w_dot2_prod[2*W-1:0]),
        .o_quo   (w_div1_quo),
        .o_sat   (w_div1_sat),
        .o_stat  (w_div1_stat)
    );

    // Sequencer: every word ends in S_FIN with its result staged in r_pend_*.
    always_comb begin
        n_state     = r_state;
        n_pend_re   = r_pend_re;
        n_pend_im   = r_pend_im;
        n_pend_st   = r_pend_st;
        n_is_div    = r_is_div;
        w_dot_start = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state   = S_FIN;
                    n_pend_re = r_acc_re;
                    n_pend_im = r_acc_im;
                    n_pend_st = cxa_pkg::ST_OK;
                    case (w_mode)
                        cxa_pkg::MODE_LOAD: begin
                            n_pend_re = i_in.operand_real;
                            n_pend_im = i_in.operand_imag;
                        end
                        cxa_pkg::MODE_ADD, cxa_pkg::MODE_SUB: begin
                            n_pend_re = w_as_re.val;
                            n_pend_im = w_as_im.val;
                            n_pend_st = (w_as_re.sat || w_as_im.sat) ? cxa_pkg::ST_SAT
                                                                     : cxa_pkg::ST_OK;
                        end
                        cxa_pkg::MODE_MUL: begin
                            w_dot_start = 1'b1;
                            n_is_div    = 1'b0;
                            n_state     = S_DOT;
                        end
                        cxa_pkg::MODE_DIV: begin
                            if (w_zero_den) begin
                                // reject: hold the accumulator
                                n_pend_st = cxa_pkg::ST_DIV_ZERO;
                            end else begin
                                w_dot_start = 1'b1;
                                n_is_div    = 1'b1;
                                n_state     = S_DOT;
                            end
                        end
                        default: begin
                            // read only, and the spare codes behave as read
                            n_pend_st = cxa_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_DOT: begin
                if (w_dots_done) begin
                    if (r_is_div) begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end else begin
                        n_pend_re = w_mc_re.val;
                        n_pend_im = w_mc_im.val;
                        n_pend_st = (w_mc_re.sat || w_mc_im.sat) ? cxa_pkg::ST_SAT
                                                                 : cxa_pkg::ST_OK;
                        n_state   = S_FIN;
                    end
                end
            end
            S_DIV: begin
                if (w_divs_done) begin
                    n_pend_re = w_div0_quo;
                    n_pend_im = w_div1_quo;
                    n_pend_st = (w_div0_sat || w_div1_sat) ? cxa_pkg::ST_SAT
                                                           : cxa_pkg::ST_OK;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc_re    <= '0;
            r_acc_im    <= '0;
            r_is_div    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_is_div <= n_is_div;
            if ((r_state == S_FIN) && w_out_free) begin
                // write back: accumulator and output word advance together
                r_acc_re    <= r_pend_re;
                r_acc_im    <= r_pend_im;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_re <= n_pend_re;
        r_pend_im <= n_pend_im;
        r_pend_st <= n_pend_st;
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_re <= r_pend_re;
            r_out_im <= r_pend_im;
            r_out_st <= r_pend_st;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_real = r_out_re;
    assign o_out.result_imag = r_out_im;
    assign o_out.status      = r_out_st;

    // no arithmetic unit may still be working while a new word can enter
    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !(w_dot0_stat.busy || w_dot1_stat.busy || w_dot2_stat.busy ||
                         w_div0_stat.busy || w_div1_stat.busy))
        else $error("arithmetic unit busy while input is ready");

    // a held output word always mirrors the accumulator
    a_out_is_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.result_real == r_acc_re) && (o_out.result_imag == r_acc_im))
        else $error("output word differs from accumulator");

    // a saturated result has at least one part on a bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == cxa_pkg::ST_SAT)) |->
            ((o_out.result_real == cxa_pkg::WORD_MAX) ||
             (o_out.result_real == cxa_pkg::WORD_MIN) ||
             (o_out.result_imag == cxa_pkg::WORD_MAX) ||
             (o_out.result_imag == cxa_pkg::WORD_MIN)))
        else $error("saturation flagged without a clamped part");

    // one word at a time: input closes straight after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("second word accepted while first in flight");

endmodule

`default_nettype wire
